// ----- rtl/skrt_pkg.sv -----
// shared types and constants for the sorted keyed record table
`timescale 1ns / 1ps
package skrt_pkg;
  localparam int CAPACITY_DEF = 32;
  localparam int KEY_BYTES_DEF = 24;
  localparam int REC_W = 64 * 6 + 2 + 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_DUMP = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;
  localparam logic [2:0] ST_ENTRY = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic wr_new;
    logic move_up;
    logic inc;
    logic dec;
    logic emit;
    logic emit_rec;
    logic last;
    logic [2:0] status;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic rd_valid;
    logic lt;
    logic eq;
  } sts_t;

  function automatic logic [63:0] key_mask(input int w, input int key_bytes);
    int bytes;
    logic [63:0] m;
    bytes = key_bytes - 8 * w;
    if (bytes <= 0) m = '0;
    else if (bytes >= 8) m = '1;
    else m = ~((64'd1 << (64 - 8 * bytes)) - 64'd1);
    return m;
  endfunction
endpackage

// ----- rtl/skrt_datapath.sv -----
// record memory, key compare and result registers
`timescale 1ns / 1ps
module skrt_datapath #(
  parameter int CAPACITY = skrt_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = skrt_pkg::KEY_BYTES_DEF,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic clk,
  input  logic rst,
  input  skrt_pkg::ctl_t ctl,
  input  logic [IW-1:0] rd_addr,
  input  logic [IW-1:0] wr_addr,
  output skrt_pkg::sts_t sts,
  input  logic [1:0] opcode,
  input  logic [63:0] name_word0,
  input  logic [63:0] name_word1,
  input  logic [63:0] name_word2,
  input  logic [63:0] major_word0,
  input  logic [63:0] major_word1,
  input  logic [63:0] major_word2,
  input  logic [1:0] year_code,
  input  logic [31:0] record_id,
  output logic [1:0] op,
  output logic [CW-1:0] count,
  output logic strobe,
  output logic [2:0] status,
  output logic [5:0] entry_count,
  output logic last_item,
  output logic [63:0] out_name0,
  output logic [63:0] out_name1,
  output logic [63:0] out_name2,
  output logic [63:0] out_major0,
  output logic [63:0] out_major1,
  output logic [63:0] out_major2,
  output logic [1:0] out_year,
  output logic [31:0] out_id
);
  localparam int RW = skrt_pkg::REC_W;
  logic [RW-1:0] mem [CAPACITY];
  logic [RW-1:0] new_rec;
  logic [RW-1:0] rd_data;
  logic [191:0] key;
  logic rd_valid;
  logic [191:0] rd_key;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op <= opcode;
      new_rec <= {name_word0 & skrt_pkg::key_mask(0, KEY_BYTES),
                  name_word1 & skrt_pkg::key_mask(1, KEY_BYTES),
                  name_word2 & skrt_pkg::key_mask(2, KEY_BYTES),
                  major_word0, major_word1, major_word2, year_code, record_id};
    end
    if (ctl.rd) rd_data <= mem[rd_addr];
    if (ctl.wr) mem[wr_addr] <= ctl.wr_new ? new_rec : rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      count <= '0;
      strobe <= 1'b0;
    end else begin
      rd_valid <= ctl.rd;
      strobe <= ctl.emit;
      if (ctl.inc) count <= count + CW'(1);
      else if (ctl.dec) count <= count - CW'(1);
    end
  end

  assign key = new_rec[RW-1 -: 192];
  assign rd_key = rd_data[RW-1 -: 192];
  assign sts.rd_valid = rd_valid;
  assign sts.lt = key < rd_key;
  assign sts.eq = key == rd_key;

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status <= ctl.status;
      entry_count <= 6'(count + (ctl.inc ? CW'(1) : CW'(0)) - (ctl.dec ? CW'(1) : CW'(0)));
      last_item <= ctl.last;
      {out_name0, out_name1, out_name2, out_major0, out_major1, out_major2,
       out_year, out_id} <= ctl.emit_rec ? rd_data : '0;
    end
  end
endmodule

// ----- rtl/skrt_ctrl.sv -----
// sequencer for insert, remove and dump
`timescale 1ns / 1ps
module skrt_ctrl #(
  parameter int CAPACITY = skrt_pkg::CAPACITY_DEF,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] op,
  input  logic [CW-1:0] count,
  input  skrt_pkg::sts_t sts,
  output skrt_pkg::ctl_t ctl,
  output logic [IW-1:0] rd_addr,
  output logic [IW-1:0] wr_addr
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_SHUP = 3'd3;
  localparam logic [2:0] S_SHDN = 3'd4;
  localparam logic [2:0] S_DUMP = 3'd5;

  logic [2:0] state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      pos <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      pos <= pos_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    idx_next = idx;
    pos_next = pos;
    ctl = '0;
    rd_addr = idx[IW-1:0];
    wr_addr = idx[IW-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        idx_next = '0;
        if (op == skrt_pkg::OP_DUMP || op == skrt_pkg::OP_REMOVE) begin
          if (count == '0) begin
            ctl.emit = 1'b1;
            ctl.last = 1'b1;
            ctl.status = skrt_pkg::ST_EMPTY;
            state_next = S_IDLE;
          end else begin
            ctl.rd = 1'b1;
            rd_addr = '0;
            state_next = (op == skrt_pkg::OP_DUMP) ? S_DUMP : S_SRCH;
          end
        end else if (op == skrt_pkg::OP_INSERT) begin
          if (count == '0) begin
            ctl.wr = 1'b1;
            ctl.wr_new = 1'b1;
            wr_addr = '0;
            ctl.inc = 1'b1;
            ctl.emit = 1'b1;
            ctl.last = 1'b1;
            ctl.status = skrt_pkg::ST_INSERTED;
            state_next = S_IDLE;
          end else begin
            ctl.rd = 1'b1;
            rd_addr = '0;
            state_next = S_SRCH;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SRCH: begin
        if (sts.rd_valid) begin
          if (op == skrt_pkg::OP_INSERT && (sts.lt || sts.eq)) begin
            if (sts.eq || count == CW'(CAPACITY)) begin
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
              ctl.status = sts.eq ? skrt_pkg::ST_DUPLICATE : skrt_pkg::ST_FULL;
              state_next = S_IDLE;
            end else begin
              pos_next = idx;
              idx_next = count;
              ctl.rd = 1'b1;
              rd_addr = IW'(count - CW'(1));
              state_next = S_SHUP;
            end
          end else if (op == skrt_pkg::OP_REMOVE && sts.eq) begin
            idx_next = idx + CW'(1);
            if (idx + CW'(1) == count) begin
              ctl.dec = 1'b1;
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
              ctl.status = skrt_pkg::ST_REMOVED;
              state_next = S_IDLE;
            end else begin
              ctl.rd = 1'b1;
              rd_addr = IW'(idx + CW'(1));
              state_next = S_SHDN;
            end
          end else if (idx + CW'(1) == count) begin
            if (op == skrt_pkg::OP_REMOVE) begin
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
              ctl.status = skrt_pkg::ST_NOTFOUND;
              state_next = S_IDLE;
            end else if (count == CW'(CAPACITY)) begin
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
              ctl.status = skrt_pkg::ST_FULL;
              state_next = S_IDLE;
            end else begin
              ctl.wr = 1'b1;
              ctl.wr_new = 1'b1;
              wr_addr = IW'(count);
              ctl.inc = 1'b1;
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
              ctl.status = skrt_pkg::ST_INSERTED;
              state_next = S_IDLE;
            end
          end else begin
            idx_next = idx + CW'(1);
            ctl.rd = 1'b1;
            rd_addr = IW'(idx + CW'(1));
          end
        end
      end
      S_SHUP: begin
        // idx is the slot written, holding entry idx-1
        if (sts.rd_valid) begin
          ctl.wr = 1'b1;
          wr_addr = IW'(idx);
          idx_next = idx - CW'(1);
          if (idx - CW'(1) != pos) begin
            ctl.rd = 1'b1;
            rd_addr = IW'(idx - CW'(2));
          end
        end else begin
          // no read in flight: the new record goes into the freed slot
          ctl.wr = 1'b1;
          ctl.wr_new = 1'b1;
          wr_addr = IW'(pos);
          ctl.inc = 1'b1;
          ctl.emit = 1'b1;
          ctl.last = 1'b1;
          ctl.status = skrt_pkg::ST_INSERTED;
          state_next = S_IDLE;
        end
      end
      S_SHDN: begin
        if (sts.rd_valid) begin
          ctl.wr = 1'b1;
          wr_addr = IW'(idx - CW'(1));
          idx_next = idx + CW'(1);
          if (idx + CW'(1) == count) begin
            ctl.dec = 1'b1;
            ctl.emit = 1'b1;
            ctl.last = 1'b1;
            ctl.status = skrt_pkg::ST_REMOVED;
            state_next = S_IDLE;
          end else begin
            ctl.rd = 1'b1;
            rd_addr = IW'(idx + CW'(1));
          end
        end
      end
      S_DUMP: begin
        if (sts.rd_valid) begin
          ctl.emit = 1'b1;
          ctl.emit_rec = 1'b1;
          ctl.status = skrt_pkg::ST_ENTRY;
          idx_next = idx + CW'(1);
          if (idx + CW'(1) == count) begin
            ctl.last = 1'b1;
            state_next = S_IDLE;
          end else begin
            ctl.rd = 1'b1;
            rd_addr = IW'(idx + CW'(1));
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- rtl/sorted_keyed_record_table.sv -----
// top level of the sorted keyed record table
// usage:
//   raise start with opcode and record fields; the transfer happens on an
//   edge where start is high and busy is low. busy stays high until the
//   operation is done.
//   results leave on strobe, one cycle each, with status, entry_count and
//   last_item; dump entries also carry the record fields. each result
//   strobes in the cycle after the busy cycle that produced it.
//   a decode state comes first, then:
//   insert: search reads one entry a cycle up to the insert slot, the shift
//   moves one entry a cycle, then the new record is written; an append at
//   the end skips the shift, and a rejected insert ends early.
//   remove: search then shift down one entry a cycle.
//   dump: one result per cycle.
//   an empty table or opcode 3 keeps busy for one cycle.
//   the single record memory port pair sets these rates.
//   reset empties the table; stored records are not cleared.
//   the receiver cannot stall; every strobe is a transfer.
//   opcode 3 gives no result and leaves the table unchanged.
`timescale 1ns / 1ps
module sorted_keyed_record_table #(
  parameter int CAPACITY = skrt_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = skrt_pkg::KEY_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] opcode,
  input  logic [63:0] name_word0,
  input  logic [63:0] name_word1,
  input  logic [63:0] name_word2,
  input  logic [63:0] major_word0,
  input  logic [63:0] major_word1,
  input  logic [63:0] major_word2,
  input  logic [1:0] year_code,
  input  logic [31:0] record_id,
  output logic strobe,
  output logic [2:0] status,
  output logic [5:0] entry_count,
  output logic last_item,
  output logic [63:0] out_name0,
  output logic [63:0] out_name1,
  output logic [63:0] out_name2,
  output logic [63:0] out_major0,
  output logic [63:0] out_major1,
  output logic [63:0] out_major2,
  output logic [1:0] out_year,
  output logic [31:0] out_id
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  skrt_pkg::ctl_t ctl;
  skrt_pkg::sts_t sts;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [1:0] op;
  logic [CW-1:0] count;

  skrt_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk, .rst, .start, .busy, .op, .count, .sts, .ctl, .rd_addr, .wr_addr
  );

  skrt_datapath #(.CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES)) u_dp (
    .clk, .rst, .ctl, .rd_addr, .wr_addr, .sts, .opcode,
    .name_word0, .name_word1, .name_word2,
    .major_word0, .major_word1, .major_word2, .year_code, .record_id,
    .op, .count, .strobe, .status, .entry_count, .last_item,
    .out_name0, .out_name1, .out_name2, .out_major0, .out_major1, .out_major2,
    .out_year, .out_id
  );

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("count above capacity");
  a_busy_on_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("transfer did not raise busy");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("result without operation");
`endif
endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the sorted keyed record table
`timescale 1ns / 1ps
module tb_top;
  localparam int CAP = skrt_pkg::CAPACITY_DEF;
  localparam int LIMIT = 2000000;
  // opcode with no operation behind it
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] count;
    logic last;
    logic [63:0] n0, n1, n2, m0, m1, m2;
    logic [1:0] year;
    logic [31:0] id;
  } res_t;

  typedef struct packed {
    logic [63:0] n0, n1, n2, m0, m1, m2;
    logic [1:0] year;
    logic [31:0] id;
  } rec_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] opcode = '0;
  logic [63:0] name_word0 = '0, name_word1 = '0, name_word2 = '0;
  logic [63:0] major_word0 = '0, major_word1 = '0, major_word2 = '0;
  logic [1:0] year_code = '0;
  logic [31:0] record_id = '0;
  logic strobe;
  logic [2:0] status;
  logic [5:0] entry_count;
  logic last_item;
  logic [63:0] out_name0, out_name1, out_name2, out_major0, out_major1, out_major2;
  logic [1:0] out_year;
  logic [31:0] out_id;

  rec_t table_q[$];
  res_t expected_q[$];
  rec_t known_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  sorted_keyed_record_table u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // key compare: -1, 0, 1
  function automatic int key_order(rec_t a, rec_t b);
    if (a.n0 != b.n0) return a.n0 < b.n0 ? -1 : 1;
    if (a.n1 != b.n1) return a.n1 < b.n1 ? -1 : 1;
    if (a.n2 != b.n2) return a.n2 < b.n2 ? -1 : 1;
    return 0;
  endfunction

  function automatic res_t plain(logic [2:0] st);
    res_t r;
    r = '0;
    r.status = st;
    r.count = 6'(table_q.size());
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_table(logic [1:0] op, rec_t rec);
    int pos;
    res_t r;
    pos = table_q.size();
    if (op == skrt_pkg::OP_INSERT) begin
      foreach (table_q[i]) if (key_order(rec, table_q[i]) <= 0) begin
        pos = i;
        break;
      end
      if (pos < table_q.size() && key_order(rec, table_q[pos]) == 0)
        expected_q.push_back(plain(skrt_pkg::ST_DUPLICATE));
      else if (table_q.size() >= CAP) expected_q.push_back(plain(skrt_pkg::ST_FULL));
      else begin
        table_q.insert(pos, rec);
        expected_q.push_back(plain(skrt_pkg::ST_INSERTED));
      end
    end else if (op == skrt_pkg::OP_REMOVE) begin
      if (table_q.size() == 0) expected_q.push_back(plain(skrt_pkg::ST_EMPTY));
      else begin
        pos = -1;
        foreach (table_q[i]) if (key_order(rec, table_q[i]) == 0) pos = i;
        if (pos < 0) expected_q.push_back(plain(skrt_pkg::ST_NOTFOUND));
        else begin
          table_q.delete(pos);
          expected_q.push_back(plain(skrt_pkg::ST_REMOVED));
        end
      end
    end else if (op == skrt_pkg::OP_DUMP) begin
      if (table_q.size() == 0) expected_q.push_back(plain(skrt_pkg::ST_EMPTY));
      else foreach (table_q[i]) begin
        r = plain(skrt_pkg::ST_ENTRY);
        r.last = (i == table_q.size() - 1);
        {r.n0, r.n1, r.n2, r.m0, r.m1, r.m2, r.year, r.id} = table_q[i];
        expected_q.push_back(r);
      end
    end
  endtask

  // start stays high after the transfer until a gap or a drain lowers it
  task automatic send(logic [1:0] op, rec_t rec);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    opcode <= op;
    {name_word0, name_word1, name_word2, major_word0, major_word1, major_word2,
     year_code, record_id} <= rec;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table(op, rec);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && strobe) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result status %0d", status);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (want.status != status) begin
          $error("status exp %0d got %0d", want.status, status); errors++; end
        if (want.count != entry_count) begin
          $error("entry_count exp %0d got %0d", want.count, entry_count); errors++; end
        if (want.last != last_item) begin
          $error("last_item exp %0d got %0d", want.last, last_item); errors++; end
        if (want.n0 != out_name0) begin
          $error("out_name0 exp %h got %h", want.n0, out_name0); errors++; end
        if (want.n1 != out_name1) begin
          $error("out_name1 exp %h got %h", want.n1, out_name1); errors++; end
        if (want.n2 != out_name2) begin
          $error("out_name2 exp %h got %h", want.n2, out_name2); errors++; end
        if (want.m0 != out_major0) begin
          $error("out_major0 exp %h got %h", want.m0, out_major0); errors++; end
        if (want.m1 != out_major1) begin
          $error("out_major1 exp %h got %h", want.m1, out_major1); errors++; end
        if (want.m2 != out_major2) begin
          $error("out_major2 exp %h got %h", want.m2, out_major2); errors++; end
        if (want.year != out_year) begin
          $error("out_year exp %0d got %0d", want.year, out_year); errors++; end
        if (want.id != out_id) begin
          $error("out_id exp %h got %h", want.id, out_id); errors++; end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic rec_t rand_rec();
    rec_t r;
    r = {rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
         2'($urandom), 32'($urandom)};
    return r;
  endfunction

  // names from a small pool so collisions and exact hits happen
  function automatic rec_t pool_rec();
    rec_t r;
    r = rand_rec();
    r.n0 = {8'h41 + 8'($urandom_range(0, 5)), 56'h0};
    r.n1 = $urandom_range(0, 3) == 0 ? 64'h0 : {56'h0, 8'($urandom_range(0, 7))};
    r.n2 = $urandom_range(0, 3) == 0 ? 64'hffff_ffff_ffff_ffff : 64'h0;
    return r;
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_empty_cases();
    rec_t r;
    r = rand_rec();
    send(skrt_pkg::OP_DUMP, r);
    send(skrt_pkg::OP_REMOVE, r);
    send(OP_NONE, r);
  endtask

  task automatic test_extremes();
    rec_t r;
    r = '0;
    send(skrt_pkg::OP_INSERT, r);
    r = '1;
    send(skrt_pkg::OP_INSERT, r);
    send(skrt_pkg::OP_INSERT, r);
    r = '0;
    r.n0 = 64'h4100_4200_0000_0000;
    send(skrt_pkg::OP_INSERT, r);
    r.n2 = 64'h1;
    send(skrt_pkg::OP_INSERT, r);
    send(skrt_pkg::OP_REMOVE, r);
    send(skrt_pkg::OP_REMOVE, r);
    send(OP_NONE, rand_rec());
    send(skrt_pkg::OP_DUMP, r);
  endtask

  task automatic test_fill();
    rec_t r;
    for (int i = 0; i < CAP + 2; i++) begin
      r = rand_rec();
      send(skrt_pkg::OP_INSERT, r);
      if (i == 5) known_q.push_back(r);
    end
    send(skrt_pkg::OP_INSERT, known_q[0]);
    send(skrt_pkg::OP_DUMP, r);
    drain();
    while (table_q.size() > 0)
      send(skrt_pkg::OP_REMOVE, table_q[$urandom_range(0, table_q.size() - 1)]);
    send(skrt_pkg::OP_DUMP, r);
    drain();
  endtask

  task automatic test_random();
    int pick;
    for (int i = 0; i < 300; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) send(skrt_pkg::OP_INSERT, pool_rec());
      else if (pick < 16) send(skrt_pkg::OP_REMOVE, pool_rec());
      else if (pick < 18) send(skrt_pkg::OP_DUMP, pool_rec());
      else if (pick == 18) send(skrt_pkg::OP_INSERT, rand_rec());
      else send(OP_NONE, rand_rec());
      if (i == 150) drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_cases();
    test_extremes();
    test_fill();
    test_random();
    drain();
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
